FILE: rtl/ibmt_pkg.sv
// ----------------------------------------------------------------------------
// ibmt_pkg
// shared types and constants of the address filter table
// ----------------------------------------------------------------------------
package ibmt_pkg;

    localparam int TableDepth = 16;
    localparam int MaxResults = 16;

    typedef enum logic [2:0] {
        CMD_PKT_IN    = 3'd0,
        CMD_PKT_OUT   = 3'd1,
        CMD_BLOCK     = 3'd2,
        CMD_UNBLOCK   = 3'd3,
        CMD_MONITOR   = 3'd4,
        CMD_UNMONITOR = 3'd5,
        CMD_QUERY     = 3'd6,
        CMD_DUMP      = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_IN   = 2'd1,
        DIR_OUT  = 2'd2
    } t_dir;

    typedef enum logic [0:0] {
        CFG_BLOCK_ALL_IN  = 1'b0,
        CFG_BLOCK_ALL_OUT = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DUMP
    } t_state;

endpackage

FILE: rtl/ip_block_monitor_table_core.sv
// ----------------------------------------------------------------------------
// ip_block_monitor_table_core
// address filter table with block and monitor flags and per-entry counters
// ----------------------------------------------------------------------------
// A request is taken when i_start is high and o_busy is low; each result
// appears for one cycle with o_strobe and cannot be held off. For every request
// but dump, the address match against the flag and address registers and the
// counter memory read happen in the accept cycle, the read-modify-write of the
// counter memory and the result in the next. A dump gives one result per cycle
// for each monitored entry, up to sixteen, read from the counter memory one
// entry at a time; with no monitored entry it gives a single result. o_busy is
// high in every cycle that gives a result.
module ip_block_monitor_table_core #(
    parameter int TABLE_DEPTH = ibmt_pkg::TableDepth
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  ibmt_pkg::t_cfg_idx    i_cfg_idx,
    input  logic                  i_cfg_data,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [2:0]            i_cmd,
    input  logic [31:0]           i_ip_addr,
    output logic                  o_strobe,
    output logic                  o_drop,
    output logic                  o_status,
    output logic                  o_hit,
    output logic [31:0]           o_entry_addr,
    output logic                  o_entry_blocked,
    output logic                  o_entry_monitored,
    output logic [1:0]            o_entry_direction,
    output logic [31:0]           o_accepted_count,
    output logic [31:0]           o_dropped_count,
    output logic                  o_last
);
    import ibmt_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(MaxResults + 1);
    localparam int MW = 66;

    typedef struct packed {
        logic          found;
        logic [IW-1:0] idx;
    } t_find;

    function automatic t_find first_set(input logic [TABLE_DEPTH-1:0] vec);
        t_find f;
        f.found = 1'b0;
        f.idx   = '0;
        for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
            if (vec[k]) begin
                f.found = 1'b1;
                f.idx   = IW'(k);
            end
        end
        return f;
    endfunction

    t_state r_state, n_state;

    logic                   r_all_in, r_all_out;
    logic [TABLE_DEPTH-1:0] r_valid, r_blk, r_mon;
    logic [31:0]            r_slot_addr [TABLE_DEPTH];
    logic [MW-1:0]          mem [TABLE_DEPTH];
    logic [MW-1:0]          r_rd;

    t_cmd           r_cmd;
    logic [31:0]    r_addr;
    logic           r_hit, r_free_ok, r_all;
    logic [IW-1:0]  r_idx, r_free_idx, r_ptr;
    logic [CW-1:0]  r_cnt;

    logic [TABLE_DEPTH-1:0] match_vec, dump_vec, above_vec;
    t_find match_f, free_f, dmon_f, next_f;
    logic [IW-1:0] rd_addr;
    logic accept;

    always_comb begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            match_vec[k] = r_valid[k] && (r_slot_addr[k] == i_ip_addr);
            above_vec[k] = r_valid[k] && r_mon[k] && (IW'(k) > r_ptr);
        end
        dump_vec = r_valid & r_mon;
        match_f  = first_set(match_vec);
        free_f   = first_set(~r_valid);
        dmon_f   = first_set(dump_vec);
        next_f   = first_set(above_vec);
    end

    assign accept = i_start && !o_busy;
    assign o_busy = (r_state != ST_IDLE);

    logic dump_last;
    assign dump_last = !next_f.found || (r_cnt == CW'(MaxResults - 1));

    always_comb begin
        if (r_state == ST_DUMP) begin
            rd_addr = next_f.idx;
        end else if (t_cmd'(i_cmd) == CMD_DUMP) begin
            rd_addr = dmon_f.idx;
        end else begin
            rd_addr = match_f.idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= mem[rd_addr];
    end

    logic [1:0]  rd_dir;
    logic [31:0] rd_acc, rd_drp;
    assign rd_dir = r_rd[65:64];
    assign rd_acc = r_rd[63:32];
    assign rd_drp = r_rd[31:0];

    logic          e_blk, e_mon, e_clear, e_we;
    logic [1:0]    e_dir;
    logic [31:0]   e_acc, e_drp;
    logic [IW-1:0] e_waddr;

    always_comb begin
        e_blk   = r_blk[r_idx];
        e_mon   = r_mon[r_idx];
        e_dir   = rd_dir;
        e_acc   = rd_acc;
        e_drp   = rd_drp;
        e_clear = 1'b0;
        e_we    = 1'b0;
        e_waddr = r_idx;
        o_drop   = 1'b0;
        o_status = 1'b0;
        o_hit    = 1'b0;
        case (r_cmd)
            CMD_PKT_IN, CMD_PKT_OUT: begin
                if (r_all) begin
                    o_drop = 1'b1;
                end else if (r_hit) begin
                    e_dir  = (r_cmd == CMD_PKT_IN) ? DIR_IN : DIR_OUT;
                    e_acc  = rd_acc + 32'(e_mon && !e_blk);
                    e_drp  = rd_drp + 32'(e_mon && e_blk);
                    e_we   = 1'b1;
                    o_drop = e_blk;
                    o_hit  = 1'b1;
                end
            end
            CMD_BLOCK, CMD_MONITOR: begin
                if (r_hit) begin
                    if (r_cmd == CMD_BLOCK) begin
                        e_blk = 1'b1;
                    end else if (!e_mon) begin
                        e_mon = 1'b1;
                        e_acc = '0;
                        e_we  = 1'b1;
                    end
                    o_hit = 1'b1;
                end else if (r_free_ok) begin
                    e_dir   = DIR_NONE;
                    e_acc   = '0;
                    e_drp   = '0;
                    e_we    = 1'b1;
                    e_waddr = r_free_idx;
                end else begin
                    o_status = 1'b1;
                end
            end
            CMD_UNBLOCK, CMD_UNMONITOR: begin
                if (r_hit) begin
                    if (r_cmd == CMD_UNBLOCK) begin
                        e_blk = 1'b0;
                    end else begin
                        e_mon = 1'b0;
                    end
                    e_clear = !e_blk && !e_mon;
                    o_hit   = 1'b1;
                end
            end
            CMD_QUERY: begin
                o_hit = r_hit;
            end
            default: begin
            end
        endcase
        if (r_state == ST_DUMP) begin
            e_blk = r_blk[r_ptr];
            e_mon = 1'b1;
            e_we  = 1'b0;
            o_hit = 1'b1;
        end
    end

    always_comb begin
        o_strobe          = (r_state == ST_EXEC) || (r_state == ST_DUMP);
        o_last            = (r_state == ST_EXEC) || dump_last;
        o_entry_addr      = '0;
        o_entry_blocked   = 1'b0;
        o_entry_monitored = 1'b0;
        o_entry_direction = '0;
        o_accepted_count  = '0;
        o_dropped_count   = '0;
        if (o_hit) begin
            o_entry_addr      = (r_state == ST_DUMP) ? r_slot_addr[r_ptr] : r_addr;
            o_entry_blocked   = e_blk;
            o_entry_monitored = e_mon;
            o_entry_direction = e_dir;
            o_accepted_count  = e_acc;
            o_dropped_count   = e_drp;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (t_cmd'(i_cmd) == CMD_DUMP && dmon_f.found) begin
                        n_state = ST_DUMP;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_EXEC: n_state = ST_IDLE;
            ST_DUMP: begin
                if (dump_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_all_in  <= 1'b0;
            r_all_out <= 1'b0;
            r_valid   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BLOCK_ALL_IN:  r_all_in  <= i_cfg_data;
                    CFG_BLOCK_ALL_OUT: r_all_out <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_state == ST_EXEC) begin
                if ((r_cmd == CMD_BLOCK || r_cmd == CMD_MONITOR) && !r_hit && r_free_ok) begin
                    r_valid[r_free_idx] <= 1'b1;
                end
                if (e_clear) begin
                    r_valid[r_idx] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= t_cmd'(i_cmd);
            r_addr     <= i_ip_addr;
            r_hit      <= match_f.found;
            r_idx      <= match_f.idx;
            r_free_ok  <= free_f.found;
            r_free_idx <= free_f.idx;
            r_all      <= (t_cmd'(i_cmd) == CMD_PKT_IN) ? r_all_in : r_all_out;
            r_ptr      <= dmon_f.idx;
            r_cnt      <= '0;
        end else if (r_state == ST_DUMP) begin
            r_ptr <= next_f.idx;
            r_cnt <= r_cnt + CW'(1);
        end
        if (r_state == ST_EXEC) begin
            if (e_we) begin
                mem[e_waddr] <= {e_dir, e_acc, e_drp};
            end
            if (r_cmd == CMD_BLOCK || r_cmd == CMD_MONITOR) begin
                if (r_hit) begin
                    r_blk[r_idx] <= e_blk;
                    r_mon[r_idx] <= e_mon;
                end else if (r_free_ok) begin
                    r_slot_addr[r_free_idx] <= r_addr;
                    r_blk[r_free_idx]       <= (r_cmd == CMD_BLOCK);
                    r_mon[r_free_idx]       <= (r_cmd == CMD_MONITOR);
                end
            end else if ((r_cmd == CMD_UNBLOCK || r_cmd == CMD_UNMONITOR) && r_hit) begin
                r_blk[r_idx] <= e_blk;
                r_mon[r_idx] <= e_mon;
            end
        end
    end

endmodule

FILE: tb/sv/tb_ip_block_monitor_table_core.sv
// ----------------------------------------------------------------------------
// tb_ip_block_monitor_table_core
// self-checking bench for the address filter table: a queued request driver
// with random gaps, a predictor of the table and counters, and a monitor that
// compares every result field against the predicted results in order
// ----------------------------------------------------------------------------
module tb_ip_block_monitor_table_core;
    import ibmt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 2000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] addr;
    } t_req;

    typedef struct packed {
        logic        drop;
        logic        status;
        logic        hit;
        logic [31:0] entry_addr;
        logic        entry_blocked;
        logic        entry_monitored;
        logic [1:0]  entry_direction;
        logic [31:0] accepted_count;
        logic [31:0] dropped_count;
        logic        last;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic        i_cfg_data;
    logic        i_start;
    logic        o_busy;
    logic [2:0]  i_cmd;
    logic [31:0] i_ip_addr;
    logic        o_strobe;
    logic        o_drop;
    logic        o_status;
    logic        o_hit;
    logic [31:0] o_entry_addr;
    logic        o_entry_blocked;
    logic        o_entry_monitored;
    logic [1:0]  o_entry_direction;
    logic [31:0] o_accepted_count;
    logic [31:0] o_dropped_count;
    logic        o_last;

    ip_block_monitor_table_core u_dut (.*);

    // predicted table
    logic        pr_all_in;
    logic        pr_all_out;
    logic        pr_valid [TableDepth];
    logic [31:0] pr_addr [TableDepth];
    logic        pr_blk [TableDepth];
    logic        pr_mon [TableDepth];
    t_dir        pr_dir [TableDepth];
    logic [31:0] pr_acc [TableDepth];
    logic [31:0] pr_drp [TableDepth];

    t_req req_q[$];
    t_res expected_q[$];
    int   mismatches;
    int   idle_cycles;
    int   gap;
    bit   timed_out;
    logic [31:0] pool [8];

    function automatic t_res entry_result(logic drop, logic status, int s, logic last);
        t_res r;
        r = '0;
        r.drop = drop;
        r.status = status;
        r.last = last;
        if (s >= 0) begin
            r.hit = 1'b1;
            r.entry_addr = pr_addr[s];
            r.entry_blocked = pr_blk[s];
            r.entry_monitored = pr_mon[s];
            r.entry_direction = pr_dir[s];
            r.accepted_count = pr_acc[s];
            r.dropped_count = pr_drp[s];
        end
        return r;
    endfunction

    function automatic int lookup(logic [31:0] a);
        for (int i = 0; i < TableDepth; i++) begin
            if (pr_valid[i] && pr_addr[i] == a) return i;
        end
        return -1;
    endfunction

    task automatic predict_table(t_req rq);
        int s;
        int n;
        t_cmd c;
        c = t_cmd'(rq.cmd);
        s = lookup(rq.addr);
        case (c)
            CMD_PKT_IN, CMD_PKT_OUT: begin
                if ((c == CMD_PKT_IN) ? pr_all_in : pr_all_out) begin
                    expected_q.push_back(entry_result(1'b1, 1'b0, -1, 1'b1));
                end else if (s < 0) begin
                    expected_q.push_back(entry_result(1'b0, 1'b0, -1, 1'b1));
                end else begin
                    pr_dir[s] = (c == CMD_PKT_IN) ? DIR_IN : DIR_OUT;
                    if (pr_mon[s]) begin
                        if (pr_blk[s]) pr_drp[s] = pr_drp[s] + 1;
                        else pr_acc[s] = pr_acc[s] + 1;
                    end
                    expected_q.push_back(entry_result(pr_blk[s], 1'b0, s, 1'b1));
                end
            end
            CMD_BLOCK, CMD_MONITOR: begin
                if (s >= 0) begin
                    if (c == CMD_BLOCK) pr_blk[s] = 1'b1;
                    else if (!pr_mon[s]) begin
                        pr_mon[s] = 1'b1;
                        pr_acc[s] = '0;
                    end
                    expected_q.push_back(entry_result(1'b0, 1'b0, s, 1'b1));
                end else begin
                    n = -1;
                    for (int i = TableDepth - 1; i >= 0; i--) begin
                        if (!pr_valid[i]) n = i;
                    end
                    if (n >= 0) begin
                        pr_valid[n] = 1'b1;
                        pr_addr[n] = rq.addr;
                        pr_blk[n] = (c == CMD_BLOCK);
                        pr_mon[n] = (c == CMD_MONITOR);
                        pr_dir[n] = DIR_NONE;
                        pr_acc[n] = '0;
                        pr_drp[n] = '0;
                    end
                    expected_q.push_back(entry_result(1'b0, n < 0, -1, 1'b1));
                end
            end
            CMD_UNBLOCK, CMD_UNMONITOR: begin
                if (s >= 0) begin
                    if (c == CMD_UNBLOCK) pr_blk[s] = 1'b0;
                    else pr_mon[s] = 1'b0;
                    expected_q.push_back(entry_result(1'b0, 1'b0, s, 1'b1));
                    if (!pr_blk[s] && !pr_mon[s]) pr_valid[s] = 1'b0;
                end else begin
                    expected_q.push_back(entry_result(1'b0, 1'b0, -1, 1'b1));
                end
            end
            CMD_QUERY: expected_q.push_back(entry_result(1'b0, 1'b0, s, 1'b1));
            default: begin
                n = 0;
                for (int i = 0; i < TableDepth && n < MaxResults; i++) begin
                    if (pr_valid[i] && pr_mon[i]) begin
                        expected_q.push_back(entry_result(1'b0, 1'b0, i, 1'b0));
                        n++;
                    end
                end
                if (n == 0) expected_q.push_back(entry_result(1'b0, 1'b0, -1, 1'b1));
                else expected_q[$].last = 1'b1;
            end
        endcase
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            gap = $urandom_range(0, 19);
        end else if (i_start && !o_busy) begin
            predict_table({i_cmd, i_ip_addr});
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 2) == 0) gap = 0;
            if (gap == 0 && req_q.size() > 0) begin
                {i_cmd, i_ip_addr} <= req_q.pop_front();
            end else begin
                i_start <= 1'b0;
            end
        end else if (!i_start) begin
            if (gap > 0) gap--;
            else if (req_q.size() > 0) begin
                {i_cmd, i_ip_addr} <= req_q.pop_front();
                i_start <= 1'b1;
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_res got;
        t_res exp_r;
        if (i_rst_n) begin
            if (o_strobe || (i_start && !o_busy)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_strobe) begin
                got = {o_drop, o_status, o_hit, o_entry_addr, o_entry_blocked,
                       o_entry_monitored, o_entry_direction, o_accepted_count,
                       o_dropped_count, o_last};
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10) $display("mismatch exp %h got %h", exp_r, got);
                    end
                end
            end
        end
    end

    task automatic push_req(t_cmd c, logic [31:0] a);
        req_q.push_back({c, a});
    endtask

    task automatic drain();
        while ((req_q.size() > 0 || i_start || expected_q.size() > 0) && !timed_out) begin
            @(posedge i_clk);
            if (idle_cycles > WatchdogLimit) timed_out = 1'b1;
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == CFG_BLOCK_ALL_IN) pr_all_in = val;
        else pr_all_out = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 15);
            push_req(t_cmd'($urandom_range(0, 7)),
                     (k < 13) ? pool[k % 8] : $urandom());
        end
    endtask

    initial begin
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        pr_all_in = 1'b0;
        pr_all_out = 1'b0;
        for (int i = 0; i < TableDepth; i++) begin
            pr_valid[i] = 1'b0;
            pr_addr[i] = '0;
            pr_blk[i] = 1'b0;
            pr_mon[i] = 1'b0;
            pr_dir[i] = DIR_NONE;
            pr_acc[i] = '0;
            pr_drp[i] = '0;
        end
        for (int i = 0; i < 8; i++) pool[i] = $urandom();
        pool[0] = 32'h0000_0000;
        pool[1] = 32'hFFFF_FFFF;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_BLOCK_ALL_IN;
        i_cfg_data = 1'b0;
        i_start = 1'b0;
        i_cmd = '0;
        i_ip_addr = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty dump, inserts, counters, frees, table full
        push_req(CMD_DUMP, 32'h0);
        push_req(CMD_MONITOR, pool[0]);
        push_req(CMD_BLOCK, pool[1]);
        push_req(CMD_MONITOR, pool[1]);
        push_req(CMD_PKT_IN, pool[1]);
        push_req(CMD_PKT_OUT, pool[0]);
        push_req(CMD_PKT_IN, pool[2]);
        push_req(CMD_QUERY, pool[1]);
        push_req(CMD_MONITOR, pool[1]);
        push_req(CMD_BLOCK, pool[0]);
        push_req(CMD_DUMP, 32'h0);
        push_req(CMD_UNBLOCK, pool[0]);
        push_req(CMD_UNMONITOR, pool[0]);
        push_req(CMD_UNMONITOR, pool[0]);
        push_req(CMD_QUERY, pool[0]);
        for (int i = 0; i < 17; i++) push_req(CMD_MONITOR, 32'h0A00_0000 + i);
        push_req(CMD_DUMP, 32'h0);
        drain();
        for (int i = 0; i < 17; i++) push_req(CMD_UNMONITOR, 32'h0A00_0000 + i);
        drain();

        write_reg(CFG_BLOCK_ALL_IN, 1'b1);
        push_req(CMD_PKT_IN, pool[1]);
        push_req(CMD_PKT_OUT, pool[1]);
        random_phase(25);
        drain();
        write_reg(CFG_BLOCK_ALL_IN, 1'b0);
        write_reg(CFG_BLOCK_ALL_OUT, 1'b1);
        random_phase(25);
        drain();
        write_reg(CFG_BLOCK_ALL_OUT, 1'b0);
        random_phase(28);
        drain();

        if (timed_out) begin
            $display("FAIL");
        end else if (mismatches == 0 && expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
